// ----- design/rbes_pkg.sv -----
package rbes_pkg;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_GRAV_X = 3'd0,
        CFG_GRAV_Y = 3'd1,
        CFG_GRAV_Z = 3'd2,
        CFG_GRAV_MAG = 3'd3,
        CFG_TIME_STEP = 3'd4,
        CFG_FLOOR_THR = 3'd5,
        CFG_CLIP_THR = 3'd6
    } t_cfg_idx;

    // Gravity direction sequencer states
    typedef enum logic [1:0] {
        DS_IDLE,
        DS_LOAD,
        DS_SHIFT,
        DS_STORE
    } t_dstate;

    // Clamped 32-bit value with its saturation flag
    typedef struct packed {
        logic [31:0] val;
        logic        sat;
    } t_qres;

    localparam logic [31:0] GRAV_X_RST = 32'd0;
    localparam logic [31:0] GRAV_Y_RST = 32'hFFF6_30A4;
    localparam logic [31:0] GRAV_Z_RST = 32'd0;
    localparam logic [30:0] GRAV_MAG_RST = 31'd642908;
    localparam logic [30:0] TIME_STEP_RST = 31'd1092;
    localparam logic [30:0] FLOOR_THR_RST = 31'd6554;
    localparam logic [30:0] CLIP_THR_RST = 31'd6554;

endpackage

// ----- design/rigid_body_euler_step_unit.sv -----
// Rigid body Euler step: one semi-implicit Euler step with floor friction and
// horizontal velocity clipping per body, in signed fixed point with FRAC_BITS
// fraction bits. A body is taken when i_start is high and o_busy is low, one
// body per clock while o_busy stays low, and its result shows up at the end of
// the pipeline for exactly one cycle with o_done high; the receiver cannot
// stall, so results must be captured when o_done is high. The pipeline holds
// the bit-serial pipelined divider of acceleration by mass (32+FRAC_BITS
// stages) plus the multiply and clamp stages around it. After reset and after
// every configuration write the gravity direction is recomputed by an
// iterative divider, with o_busy high. Configuration writes are always taken
// (o_cfg_ready is high); the user must make them only while no body is in
// flight, and the block itself does not enforce this.
module rigid_body_euler_step_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [31:0] i_pos_x,
    input  logic [31:0] i_pos_y,
    input  logic [31:0] i_pos_z,
    input  logic [31:0] i_vel_x,
    input  logic [31:0] i_vel_y,
    input  logic [31:0] i_vel_z,
    input  logic [31:0] i_acc_x,
    input  logic [31:0] i_acc_y,
    input  logic [31:0] i_acc_z,
    input  logic [30:0] i_body_mass,
    input  logic [30:0] i_friction_coef,
    input  logic        i_body_dynamic,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output logic        o_done,
    output logic [31:0] o_new_pos_x,
    output logic [31:0] o_new_pos_y,
    output logic [31:0] o_new_pos_z,
    output logic [31:0] o_new_vel_x,
    output logic [31:0] o_new_vel_y,
    output logic [31:0] o_new_vel_z,
    output logic [31:0] o_next_acc_x,
    output logic [31:0] o_next_acc_y,
    output logic [31:0] o_next_acc_z,
    output logic        o_saturated
);

    localparam int NUM_W = 32 + FRAC_BITS;
    localparam int CNT_W = $clog2(NUM_W);
    localparam int S_ACC = 1;
    localparam int S_DIV = 2;
    localparam int S_QUO = S_DIV + NUM_W;
    localparam int S_TMUL = S_QUO + 1;
    localparam int S_VEL = S_QUO + 2;
    localparam int S_VMUL = S_QUO + 3;
    localparam int S_POS = S_QUO + 4;
    localparam int S_MU = S_QUO + 5;
    localparam int S_FMU = S_QUO + 6;
    localparam int S_GM = S_QUO + 7;
    localparam int S_FGM = S_QUO + 8;
    localparam int S_SC = S_QUO + 9;
    localparam int S_OUT = S_QUO + 10;
    localparam int STAGES = S_OUT + 1;

    typedef struct packed {
        logic [2:0][31:0]      p;
        logic [2:0][31:0]      v;
        logic [2:0][31:0]      a;
        logic [2:0][31:0]      w;
        logic [30:0]           m;
        logic [30:0]           mu;
        logic                  dyn;
        logic                  sat;
        logic                  fsat;
        logic [2:0]            neg;
        logic [2:0][30:0]      rem;
        logic [2:0][NUM_W-1:0] nq;
        logic [2:0][65:0]      prod;
        logic [2:0][65:0]      prf;
        logic [2:0][65:0]      prd;
        logic [65:0]           spd;
        logic                  flr;
        logic                  clp;
    } t_stage;

    // ---------------------------------------------------------------------
    // Arithmetic helpers
    // ---------------------------------------------------------------------
    function automatic rbes_pkg::t_qres sat66(input logic signed [65:0] x);
        rbes_pkg::t_qres r;
        if (x > 66'sd2147483647) begin
            r.val = 32'h7FFF_FFFF;
            r.sat = 1'b1;
        end else if (x < -66'sd2147483648) begin
            r.val = 32'h8000_0000;
            r.sat = 1'b1;
        end else begin
            r.val = x[31:0];
            r.sat = 1'b0;
        end
        return r;
    endfunction

    function automatic rbes_pkg::t_qres qsat(input logic [65:0] x);
        return sat66($signed(x) >>> FRAC_BITS);
    endfunction

    function automatic rbes_pkg::t_qres add_sat(input logic [31:0] x, input logic [31:0] y);
        return sat66(66'($signed(x)) + 66'($signed(y)));
    endfunction

    function automatic logic [65:0] mul(input logic signed [32:0] x,
                                        input logic signed [32:0] y);
        return 66'(66'(x) * 66'(y));
    endfunction

    function automatic logic signed [32:0] s33(input logic [31:0] x);
        return $signed({x[31], x});
    endfunction

    function automatic logic signed [32:0] u33(input logic [30:0] x);
        return $signed({2'b00, x});
    endfunction

    function automatic logic [32:0] abs33(input logic [31:0] x);
        logic signed [32:0] e;
        e = s33(x);
        return (e < 0) ? $unsigned(-e) : $unsigned(e);
    endfunction

    // One restoring division step: returns {remainder, shifted numerator/quotient}
    function automatic logic [31+NUM_W-1:0] div_step(input logic [30:0] rem,
                                                     input logic [NUM_W-1:0] nq,
                                                     input logic [30:0] den);
        logic [31:0] trial;
        logic [31:0] diff;
        logic        ge;
        trial = {rem, nq[NUM_W-1]};
        diff = trial - {1'b0, den};
        ge = (trial >= {1'b0, den});
        return {(ge ? diff[30:0] : trial[30:0]), nq[NUM_W-2:0], ge};
    endfunction

    function automatic rbes_pkg::t_qres quo_sat(input logic [NUM_W-1:0] q, input logic neg);
        logic signed [65:0] z;
        z = $signed({{(66 - NUM_W){1'b0}}, q});
        return sat66(neg ? -z : z);
    endfunction

    // ---------------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------------
    logic [2:0][31:0] r_grav;
    logic [30:0]      r_gm;
    logic [30:0]      r_dt;
    logic [30:0]      r_fthr;
    logic [30:0]      r_clip;
    logic             cfg_wr;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr = i_cfg_valid & o_cfg_ready;

    // Write one register per transfer, ignore unknown indexes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grav[0] <= rbes_pkg::GRAV_X_RST;
            r_grav[1] <= rbes_pkg::GRAV_Y_RST;
            r_grav[2] <= rbes_pkg::GRAV_Z_RST;
            r_gm <= rbes_pkg::GRAV_MAG_RST;
            r_dt <= rbes_pkg::TIME_STEP_RST;
            r_fthr <= rbes_pkg::FLOOR_THR_RST;
            r_clip <= rbes_pkg::CLIP_THR_RST;
        end else if (cfg_wr) begin
            case (rbes_pkg::t_cfg_idx'(i_cfg_index))
                rbes_pkg::CFG_GRAV_X: r_grav[0] <= i_cfg_data;
                rbes_pkg::CFG_GRAV_Y: r_grav[1] <= i_cfg_data;
                rbes_pkg::CFG_GRAV_Z: r_grav[2] <= i_cfg_data;
                rbes_pkg::CFG_GRAV_MAG: r_gm <= i_cfg_data[30:0];
                rbes_pkg::CFG_TIME_STEP: r_dt <= i_cfg_data[30:0];
                rbes_pkg::CFG_FLOOR_THR: r_fthr <= i_cfg_data[30:0];
                rbes_pkg::CFG_CLIP_THR: r_clip <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Gravity direction sequencer: dir = gravity / magnitude, one bit a cycle
    // ---------------------------------------------------------------------
    rbes_pkg::t_dstate r_dstate, n_dstate;
    logic [1:0]            r_daxis, n_daxis;
    logic [CNT_W-1:0]      r_dcnt, n_dcnt;
    logic [30:0]           r_drem, n_drem;
    logic [NUM_W-1:0]      r_dnq, n_dnq;
    logic                  r_dneg, n_dneg;
    logic [2:0][31:0]      r_dir, n_dir;
    logic [2:0][32:0]      r_scale, n_scale;
    logic [2:0]            r_dsat, n_dsat;
    logic [30:0]           gm_eff;
    logic [31:0]           dgrav;
    rbes_pkg::t_qres       dquo;
    logic [32:0]           dabs;
    logic [32:0]           qone;

    assign gm_eff = (r_gm == 31'd0) ? 31'd1 : r_gm;
    assign qone = 33'd1 << FRAC_BITS;

    // Next state
    always_comb begin
        n_dstate = r_dstate;
        case (r_dstate)
            rbes_pkg::DS_IDLE: n_dstate = rbes_pkg::DS_IDLE;
            rbes_pkg::DS_LOAD: n_dstate = rbes_pkg::DS_SHIFT;
            rbes_pkg::DS_SHIFT: begin
                if (r_dcnt == CNT_W'(NUM_W - 1)) begin
                    n_dstate = rbes_pkg::DS_STORE;
                end
            end
            rbes_pkg::DS_STORE: begin
                n_dstate = (r_daxis == 2'd2) ? rbes_pkg::DS_IDLE : rbes_pkg::DS_LOAD;
            end
            default: n_dstate = rbes_pkg::DS_IDLE;
        endcase
        if (cfg_wr) begin
            n_dstate = rbes_pkg::DS_LOAD;
        end
    end

    // Datapath of the sequencer
    always_comb begin
        n_daxis = r_daxis;
        n_dcnt = r_dcnt;
        n_drem = r_drem;
        n_dnq = r_dnq;
        n_dneg = r_dneg;
        n_dir = r_dir;
        n_scale = r_scale;
        n_dsat = r_dsat;
        case (r_daxis)
            2'd0: dgrav = r_grav[0];
            2'd1: dgrav = r_grav[1];
            default: dgrav = r_grav[2];
        endcase
        dquo = quo_sat(r_dnq, r_dneg);
        dabs = abs33(dquo.val);
        case (r_dstate)
            rbes_pkg::DS_LOAD: begin
                n_dneg = dgrav[31];
                n_dnq = {abs33(dgrav)[31:0], {FRAC_BITS{1'b0}}};
                n_drem = '0;
                n_dcnt = '0;
            end
            rbes_pkg::DS_SHIFT: begin
                {n_drem, n_dnq} = div_step(r_drem, r_dnq, gm_eff);
                n_dcnt = r_dcnt + CNT_W'(1);
            end
            rbes_pkg::DS_STORE: begin
                n_dir[r_daxis] = dquo.val;
                n_scale[r_daxis] = qone - dabs;
                n_dsat[r_daxis] = dquo.sat;
                n_daxis = r_daxis + 2'd1;
            end
            default: ;
        endcase
        if (cfg_wr) begin
            n_daxis = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dstate <= rbes_pkg::DS_LOAD;
            r_daxis <= 2'd0;
        end else begin
            r_dstate <= n_dstate;
            r_daxis <= n_daxis;
        end
        r_dcnt <= n_dcnt;
        r_drem <= n_drem;
        r_dnq <= n_dnq;
        r_dneg <= n_dneg;
        r_dir <= n_dir;
        r_scale <= n_scale;
        r_dsat <= n_dsat;
    end

    assign o_busy = (r_dstate != rbes_pkg::DS_IDLE);

    // ---------------------------------------------------------------------
    // Body pipeline
    // ---------------------------------------------------------------------
    t_stage     r_pipe [STAGES];
    t_stage     n_pipe [STAGES];
    logic [STAGES-1:0] r_vld;
    logic       accept;

    assign accept = i_start & ~o_busy;

    // Capture the body and form gravity times mass
    always_comb begin
        n_pipe[0] = '0;
        n_pipe[0].p = {i_pos_z, i_pos_y, i_pos_x};
        n_pipe[0].v = {i_vel_z, i_vel_y, i_vel_x};
        n_pipe[0].a = {i_acc_z, i_acc_y, i_acc_x};
        n_pipe[0].m = (i_body_mass == 31'd0) ? 31'd1 : i_body_mass;
        n_pipe[0].mu = i_friction_coef;
        n_pipe[0].dyn = i_body_dynamic;
        for (int i = 0; i < 3; i++) begin
            n_pipe[0].prod[i] = mul(s33(r_grav[i]), u33(n_pipe[0].m));
        end
    end

    for (genvar k = 1; k < STAGES; k++) begin : g_stage
        always_comb begin
            rbes_pkg::t_qres r0;
            rbes_pkg::t_qres r1;
            logic signed [65:0] sum;
            logic signed [65:0] sabs;
            n_pipe[k] = r_pipe[k-1];
            if (k >= S_DIV && k < S_QUO) begin
                // one quotient bit per lane
                for (int i = 0; i < 3; i++) begin
                    {n_pipe[k].rem[i], n_pipe[k].nq[i]} =
                        div_step(r_pipe[k-1].rem[i], r_pipe[k-1].nq[i], r_pipe[k-1].m);
                end
            end else begin
                case (k)
                    S_ACC: begin
                        for (int i = 0; i < 3; i++) begin
                            r0 = qsat(r_pipe[k-1].prod[i]);
                            r1 = add_sat(r_pipe[k-1].a[i], r0.val);
                            n_pipe[k].w[i] = r1.val;
                            n_pipe[k].sat = n_pipe[k].sat | (r_pipe[k-1].dyn & (r0.sat | r1.sat));
                            n_pipe[k].neg[i] = r1.val[31];
                            n_pipe[k].nq[i] = {abs33(r1.val)[31:0], {FRAC_BITS{1'b0}}};
                            n_pipe[k].rem[i] = '0;
                        end
                    end
                    S_QUO: begin
                        for (int i = 0; i < 3; i++) begin
                            r0 = quo_sat(r_pipe[k-1].nq[i], r_pipe[k-1].neg[i]);
                            n_pipe[k].w[i] = r0.val;
                            n_pipe[k].sat = n_pipe[k].sat | (r_pipe[k-1].dyn & r0.sat);
                        end
                    end
                    S_TMUL: begin
                        for (int i = 0; i < 3; i++) begin
                            n_pipe[k].prod[i] = mul(s33(r_pipe[k-1].w[i]), u33(r_dt));
                        end
                    end
                    S_VEL: begin
                        for (int i = 0; i < 3; i++) begin
                            r0 = qsat(r_pipe[k-1].prod[i]);
                            r1 = add_sat(r_pipe[k-1].v[i], r0.val);
                            if (r_pipe[k-1].dyn) begin
                                n_pipe[k].v[i] = r1.val;
                            end
                            n_pipe[k].sat = n_pipe[k].sat | (r_pipe[k-1].dyn & (r0.sat | r1.sat));
                        end
                    end
                    S_VMUL: begin
                        for (int i = 0; i < 3; i++) begin
                            n_pipe[k].prod[i] = mul(s33(r_pipe[k-1].v[i]), u33(r_dt));
                            n_pipe[k].prf[i] = mul(s33(r_pipe[k-1].v[i]), u33(r_pipe[k-1].m));
                            n_pipe[k].prd[i] = mul(s33(r_pipe[k-1].v[i]), s33(r_dir[i]));
                        end
                        n_pipe[k].clp = ({1'b0, abs33(r_pipe[k-1].v[0])}
                                       + {1'b0, abs33(r_pipe[k-1].v[2])}) < {3'b000, r_clip};
                    end
                    S_POS: begin
                        sum = '0;
                        for (int i = 0; i < 3; i++) begin
                            r0 = qsat(r_pipe[k-1].prod[i]);
                            r1 = add_sat(r_pipe[k-1].p[i], r0.val);
                            if (r_pipe[k-1].dyn) begin
                                n_pipe[k].p[i] = r1.val;
                            end
                            n_pipe[k].sat = n_pipe[k].sat | (r_pipe[k-1].dyn & (r0.sat | r1.sat));
                            r0 = qsat(r_pipe[k-1].prf[i]);
                            n_pipe[k].w[i] = r0.val;
                            n_pipe[k].fsat = n_pipe[k].fsat | r0.sat;
                            sum = sum + ($signed(r_pipe[k-1].prd[i]) >>> FRAC_BITS);
                        end
                        n_pipe[k].spd = sum;
                    end
                    S_MU: begin
                        sabs = $signed(r_pipe[k-1].spd);
                        sabs = (sabs < 0) ? -sabs : sabs;
                        n_pipe[k].flr = $unsigned(sabs) < {35'd0, r_fthr};
                        for (int i = 0; i < 3; i++) begin
                            n_pipe[k].prf[i] = mul(s33(r_pipe[k-1].w[i]), u33(r_pipe[k-1].mu));
                        end
                    end
                    S_FMU, S_FGM: begin
                        for (int i = 0; i < 3; i++) begin
                            r0 = qsat(r_pipe[k-1].prf[i]);
                            n_pipe[k].w[i] = r0.val;
                            n_pipe[k].fsat = n_pipe[k].fsat | r0.sat;
                        end
                    end
                    S_GM: begin
                        for (int i = 0; i < 3; i++) begin
                            n_pipe[k].prf[i] = mul(s33(r_pipe[k-1].w[i]), u33(r_gm));
                        end
                    end
                    S_SC: begin
                        for (int i = 0; i < 3; i++) begin
                            n_pipe[k].prf[i] = mul(s33(r_pipe[k-1].w[i]), $signed(r_scale[i]));
                        end
                    end
                    S_OUT: begin
                        // friction or zero into carried acceleration, then clip
                        for (int i = 0; i < 3; i++) begin
                            r0 = qsat(r_pipe[k-1].prf[i]);
                            r1 = sat66(-66'($signed(r0.val)));
                            n_pipe[k].fsat = n_pipe[k].fsat | r0.sat | r1.sat;
                            if (r_pipe[k-1].dyn) begin
                                n_pipe[k].a[i] = r_pipe[k-1].flr ? r1.val : 32'd0;
                            end
                        end
                        n_pipe[k].sat = r_pipe[k-1].sat | (r_pipe[k-1].dyn
                                      & ((|r_dsat) | (r_pipe[k-1].flr & n_pipe[k].fsat)));
                        if (r_pipe[k-1].clp) begin
                            n_pipe[k].v[0] = 32'd0;
                            n_pipe[k].v[2] = 32'd0;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // Advance data and valid bits every cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[STAGES-2:0], accept};
        end
        for (int k = 0; k < STAGES; k++) begin
            r_pipe[k] <= n_pipe[k];
        end
    end

    assign o_done = r_vld[STAGES-1];
    assign o_new_pos_x = r_pipe[STAGES-1].p[0];
    assign o_new_pos_y = r_pipe[STAGES-1].p[1];
    assign o_new_pos_z = r_pipe[STAGES-1].p[2];
    assign o_new_vel_x = r_pipe[STAGES-1].v[0];
    assign o_new_vel_y = r_pipe[STAGES-1].v[1];
    assign o_new_vel_z = r_pipe[STAGES-1].v[2];
    assign o_next_acc_x = r_pipe[STAGES-1].a[0];
    assign o_next_acc_y = r_pipe[STAGES-1].a[1];
    assign o_next_acc_z = r_pipe[STAGES-1].a[2];
    assign o_saturated = r_pipe[STAGES-1].sat;

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> r_vld[0])
        else $error("accepted body did not enter the pipeline");

    a_fixed_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[0] |-> ##(STAGES-1) o_done)
        else $error("result did not appear after the pipeline latency");

    a_cfg_recompute: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_wr |=> o_busy)
        else $error("configuration write did not start direction update");

    a_reset_recompute: assert property (@(posedge i_clk)
        !i_rst_n |=> o_busy)
        else $error("reset did not start direction update");

endmodule
